[rtl/core/sscnt_pkg.sv]
`default_nettype none

package sscnt_pkg;

  // configuration register file
  localparam int unsigned PADDR_BITS = 3;
  localparam int unsigned PDATA_BITS = 32;
  localparam logic        REG_CAPACITY = 1'b0;

  localparam int unsigned CAP_BITS  = 11;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 11'd1024;

  // fixed field widths
  localparam int unsigned STAMP_BITS = 32;
  localparam int unsigned OUT_BITS   = 32;
  localparam int unsigned IN_BITS    = 32;

  // parameter defaults
  localparam int unsigned DEF_MAX_SLOTS  = 1024;
  localparam int unsigned DEF_KEY_BITS   = 32;
  localparam int unsigned DEF_COUNT_BITS = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_WRITE
  } sscnt_state_e;

endpackage

`default_nettype wire

[rtl/core/space_saving_counter_table_unit.sv]
// Each item is handled in steps: one read of the slot memory per used slot through the
//   shared compare unit (skipped while the table is empty), a flush state for the last read
//   to land, and a write-back state that holds while the previous result word is stalled.
// The input stalls until write-back is done; a new item is taken while the last result word
//   waits. Reset clears control, slots_used, stream count and capacity (to 1024); the slot
//   memory needs no clearing pass.
`default_nettype none

module space_saving_counter_table_unit
  import sscnt_pkg::*;
#(
  parameter int unsigned MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int unsigned KEY_BITS   = DEF_KEY_BITS,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [PDATA_BITS-1:0] pwdata,
  output logic      [PDATA_BITS-1:0] prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [IN_BITS-1:0]    item_key_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       was_tracked_o,
  output logic                       did_evict_o,
  output logic      [OUT_BITS-1:0]   evicted_key_o,
  output logic      [OUT_BITS-1:0]   estimate_o,
  output logic      [OUT_BITS-1:0]   error_bound_o,
  output logic      [OUT_BITS-1:0]   total_seen_o
);

  localparam int unsigned AW   = $clog2(MAX_SLOTS);
  localparam int unsigned CW   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CapW = (CW > CAP_BITS) ? CW : CAP_BITS;
  localparam int unsigned EW   = KEY_BITS + 2 * COUNT_BITS + STAMP_BITS;

  sscnt_state_e state_q, state_d;

  logic [CAP_BITS-1:0]   cap_q;
  logic [CW-1:0]         used_q, used_d;
  logic [CW-1:0]         scan_cnt_q, scan_cnt_d;
  logic [KEY_BITS-1:0]   key_q;
  logic [STAMP_BITS-1:0] stream_q;
  logic                  rd_valid_q;
  logic [AW-1:0]         rd_idx_q;

  logic                  accept;
  logic                  scan_clear;
  logic                  rd_en;
  logic                  wr_go;
  logic                  take_free;
  logic [CapW-1:0]       cap_ext;
  logic [CapW-1:0]       cap_eff;
  logic [63:0]           in_wide;

  logic [EW-1:0]         rd_data;
  logic [AW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;

  logic                  found;
  logic [AW-1:0]         hit_idx;
  logic [COUNT_BITS-1:0] hit_count;
  logic [COUNT_BITS-1:0] hit_error;
  logic [STAMP_BITS-1:0] hit_stamp;
  logic [AW-1:0]         victim_idx;
  logic [KEY_BITS-1:0]   victim_key;
  logic [COUNT_BITS-1:0] best_count;

  logic [COUNT_BITS-1:0] new_count;
  logic [COUNT_BITS-1:0] new_error;
  logic [STAMP_BITS-1:0] new_stamp;
  logic [63:0]           est_wide;
  logic [63:0]           err_wide;
  logic [63:0]           evk_wide;

  logic                  out_valid_q;
  logic                  was_tracked_q, did_evict_q;
  logic [OUT_BITS-1:0]   evicted_key_q, estimate_q, error_bound_q, total_seen_q;

  // configuration port
  assign pready = 1'b1;
  assign prdata = PDATA_BITS'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[PADDR_BITS-1] == REG_CAPACITY)) begin
      cap_q <= pwdata[CAP_BITS-1:0];
    end
  end

  assign cap_ext = CapW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CapW'(1);
    end else if (cap_ext > CapW'(MAX_SLOTS)) begin
      cap_eff = CapW'(MAX_SLOTS);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_wide    = 64'(item_key_i);

  // sequencer
  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    scan_clear = 1'b0;
    rd_en      = 1'b0;
    wr_go      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scan_clear = 1'b1;
          scan_cnt_d = '0;
          state_d    = (used_q == '0) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_cnt_q + CW'(1) == used_q) begin
          state_d = ST_FLUSH;
        end else begin
          scan_cnt_d = scan_cnt_q + CW'(1);
        end
      end
      ST_FLUSH: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        // hold until the previous word has left the output register
        if (!(out_valid_q && out_stall_i)) begin
          wr_go   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_cnt_q <= '0;
      used_q     <= '0;
      stream_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      used_q     <= used_d;
      rd_valid_q <= rd_en;
      if (accept && (stream_q != '1)) begin
        stream_q <= stream_q + STAMP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= in_wide[KEY_BITS-1:0];
    end
    if (rd_en) begin
      rd_idx_q <= scan_cnt_q[AW-1:0];
    end
  end

  sscnt_slot_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (EW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_go),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_cnt_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  sscnt_scan_unit #(
    .MAX_SLOTS  (MAX_SLOTS),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (scan_clear),
    .valid_i      (rd_valid_q),
    .idx_i        (rd_idx_q),
    .entry_i      (rd_data),
    .key_i        (key_q),
    .found_o      (found),
    .hit_idx_o    (hit_idx),
    .hit_count_o  (hit_count),
    .hit_error_o  (hit_error),
    .hit_stamp_o  (hit_stamp),
    .victim_idx_o (victim_idx),
    .victim_key_o (victim_key),
    .best_count_o (best_count)
  );

  // write-back of the chosen slot
  assign take_free = !found && (CapW'(used_q) < cap_eff);

  always_comb begin
    used_d = used_q;
    if (found) begin
      wr_addr = hit_idx;
      if (hit_count != '1) begin
        new_count = hit_count + COUNT_BITS'(1);
        new_stamp = stream_q;
      end else begin
        new_count = hit_count;
        new_stamp = hit_stamp;
      end
      new_error = hit_error;
    end else if (take_free) begin
      wr_addr   = used_q[AW-1:0];
      new_count = COUNT_BITS'(1);
      new_error = '0;
      new_stamp = stream_q;
      if (wr_go) begin
        used_d = used_q + CW'(1);
      end
    end else begin
      wr_addr   = victim_idx;
      new_count = (best_count != '1) ? best_count + COUNT_BITS'(1) : best_count;
      new_error = best_count;
      new_stamp = stream_q;
    end
  end

  assign wr_data  = {key_q, new_count, new_error, new_stamp};
  assign est_wide = 64'(new_count);
  assign err_wide = 64'(new_error);
  assign evk_wide = 64'(victim_key);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_go) begin
      was_tracked_q <= found;
      did_evict_q   <= !found && !take_free;
      evicted_key_q <= (!found && !take_free) ? evk_wide[OUT_BITS-1:0] : '0;
      estimate_q    <= est_wide[OUT_BITS-1:0];
      error_bound_q <= err_wide[OUT_BITS-1:0];
      total_seen_q  <= stream_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign was_tracked_o = was_tracked_q;
  assign did_evict_o   = did_evict_q;
  assign evicted_key_o = evicted_key_q;
  assign estimate_o    = estimate_q;
  assign error_bound_o = error_bound_q;
  assign total_seen_o  = total_seen_q;

  // checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(MAX_SLOTS))
    else $error("slot fill count beyond table size");

  a_free_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_go && take_free) |=> (used_q == $past(used_q) + CW'(1)))
    else $error("free slot taken without fill count advance");

  a_out_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_WRITE))
    else $error("result word raised outside write-back");

  a_stream_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (stream_q >= $past(stream_q)))
    else $error("stream count went backward");

endmodule

`default_nettype wire

[rtl/core/sscnt_slot_ram.sv]
`default_nettype none

module sscnt_slot_ram
  import sscnt_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_MAX_SLOTS,
  parameter int unsigned WIDTH = DEF_KEY_BITS + 2 * DEF_COUNT_BITS + STAMP_BITS,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/sscnt_scan_unit.sv]
`default_nettype none

module sscnt_scan_unit
  import sscnt_pkg::*;
#(
  parameter int unsigned MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int unsigned KEY_BITS   = DEF_KEY_BITS,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS,
  localparam int unsigned AW = $clog2(MAX_SLOTS),
  localparam int unsigned EW = KEY_BITS + 2 * COUNT_BITS + STAMP_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  clear_i,
  input  wire logic                  valid_i,
  input  wire logic [AW-1:0]         idx_i,
  input  wire logic [EW-1:0]         entry_i,
  input  wire logic [KEY_BITS-1:0]   key_i,
  output logic                       found_o,
  output logic [AW-1:0]              hit_idx_o,
  output logic [COUNT_BITS-1:0]      hit_count_o,
  output logic [COUNT_BITS-1:0]      hit_error_o,
  output logic [STAMP_BITS-1:0]      hit_stamp_o,
  output logic [AW-1:0]              victim_idx_o,
  output logic [KEY_BITS-1:0]        victim_key_o,
  output logic [COUNT_BITS-1:0]      best_count_o
);

  logic [KEY_BITS-1:0]   e_key;
  logic [COUNT_BITS-1:0] e_count;
  logic [COUNT_BITS-1:0] e_error;
  logic [STAMP_BITS-1:0] e_stamp;
  logic                  have_min_q;
  logic [STAMP_BITS-1:0] best_stamp_q;
  logic                  key_match;
  logic                  take_min;

  assign e_stamp = entry_i[STAMP_BITS-1:0];
  assign e_error = entry_i[STAMP_BITS +: COUNT_BITS];
  assign e_count = entry_i[STAMP_BITS+COUNT_BITS +: COUNT_BITS];
  assign e_key   = entry_i[EW-1 -: KEY_BITS];

  assign key_match = !found_o && (e_key == key_i);
  // least count wins; on a tie the newer stamp, then the later slot
  assign take_min  = !have_min_q || (e_count < best_count_o) ||
                     ((e_count == best_count_o) && (e_stamp >= best_stamp_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_o    <= 1'b0;
      have_min_q <= 1'b0;
    end else if (clear_i) begin
      found_o    <= 1'b0;
      have_min_q <= 1'b0;
    end else if (valid_i) begin
      if (key_match) begin
        found_o <= 1'b1;
      end
      if (take_min) begin
        have_min_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !clear_i) begin
      if (key_match) begin
        hit_idx_o   <= idx_i;
        hit_count_o <= e_count;
        hit_error_o <= e_error;
        hit_stamp_o <= e_stamp;
      end
      if (take_min) begin
        victim_idx_o <= idx_i;
        victim_key_o <= e_key;
        best_count_o <= e_count;
        best_stamp_q <= e_stamp;
      end
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import sscnt_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam logic [PADDR_BITS-1:0] CAP_ADDR = PADDR_BITS'(4 * REG_CAPACITY);

  typedef struct packed {
    logic        was_tracked;
    logic        did_evict;
    logic [31:0] evicted_key;
    logic [31:0] estimate;
    logic [31:0] error_bound;
    logic [31:0] total_seen;
  } hh_report_t;

  // Space-Saving table mirror: predicts the report for each key and checks words in order
  class hitter_board;
    logic [DEF_KEY_BITS-1:0]   slot_key   [DEF_MAX_SLOTS];
    logic [DEF_COUNT_BITS-1:0] slot_count [DEF_MAX_SLOTS];
    logic [DEF_COUNT_BITS-1:0] slot_error [DEF_MAX_SLOTS];
    logic [STAMP_BITS-1:0]     slot_stamp [DEF_MAX_SLOTS];
    int unsigned               slots_taken;
    logic [31:0]               stream_len;
    logic [CAP_BITS-1:0]       capacity;
    hh_report_t                pending[$];
    int unsigned               mismatches;
    int unsigned               n_hits, n_fills, n_evicts;

    function new();
      capacity    = CAP_RESET;
      slots_taken = 0;
      stream_len  = '0;
      mismatches  = 0;
      n_hits      = 0;
      n_fills     = 0;
      n_evicts    = 0;
    endfunction

    function void set_capacity(logic [31:0] value);
      capacity = value[CAP_BITS-1:0];
    endfunction

    function void count_key(logic [31:0] key);
      hh_report_t                rep;
      int unsigned               lim, slot, hit, victim;
      bit                        found, have_min;
      logic [DEF_COUNT_BITS-1:0] least;
      logic [STAMP_BITS-1:0]     least_stamp;
      lim = (capacity == 0) ? 1 : (capacity > DEF_MAX_SLOTS ? DEF_MAX_SLOTS : capacity);
      rep = '0;
      found = 1'b0;
      have_min = 1'b0;
      least = '0;
      least_stamp = '0;
      hit = 0;
      victim = 0;
      if (stream_len != '1) stream_len++;
      for (int i = 0; i < slots_taken; i++) begin
        if (!found && slot_key[i] == key) begin
          found = 1'b1;
          hit = i;
        end
        // least count wins; ties go to the newest stamp, then the higher slot
        if (!have_min || slot_count[i] < least ||
            (slot_count[i] == least && slot_stamp[i] >= least_stamp)) begin
          have_min = 1'b1;
          least = slot_count[i];
          least_stamp = slot_stamp[i];
          victim = i;
        end
      end
      if (found) begin
        slot = hit;
        rep.was_tracked = 1'b1;
        if (slot_count[slot] != '1) begin
          slot_count[slot]++;
          slot_stamp[slot] = stream_len;
        end
        n_hits++;
      end else if (slots_taken < lim) begin
        slot = slots_taken;
        slot_key[slot] = key;
        slot_count[slot] = 1;
        slot_error[slot] = '0;
        slot_stamp[slot] = stream_len;
        slots_taken++;
        n_fills++;
      end else begin
        slot = victim;
        rep.did_evict = 1'b1;
        rep.evicted_key = slot_key[slot];
        slot_key[slot] = key;
        slot_error[slot] = least;
        slot_count[slot] = (least != '1) ? least + 1 : least;
        slot_stamp[slot] = stream_len;
        n_evicts++;
      end
      rep.estimate = slot_count[slot];
      rep.error_bound = slot_error[slot];
      rep.total_seen = stream_len;
      pending.push_back(rep);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_word(hh_report_t got);
      hh_report_t want;
      if (pending.size() == 0) begin
        $display("%0t: result word with nothing pending, actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending.pop_front();
        check_field("was_tracked", 32'(want.was_tracked), 32'(got.was_tracked));
        check_field("did_evict", 32'(want.did_evict), 32'(got.did_evict));
        check_field("evicted_key", want.evicted_key, got.evicted_key);
        check_field("estimate", want.estimate, got.estimate);
        check_field("error_bound", want.error_bound, got.error_bound);
        check_field("total_seen", want.total_seen, got.total_seen);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [IN_BITS-1:0]    item_key = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  was_tracked;
  logic                  did_evict;
  logic [OUT_BITS-1:0]   evicted_key;
  logic [OUT_BITS-1:0]   estimate;
  logic [OUT_BITS-1:0]   error_bound;
  logic [OUT_BITS-1:0]   total_seen;

  hitter_board board = new();
  bit          hold_request = 1'b0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cfg_errors = 0;
  logic [31:0] hot_keys[$];

  space_saving_counter_table_unit u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .item_key_i   (item_key),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .was_tracked_o(was_tracked),
    .did_evict_o  (did_evict),
    .evicted_key_o(evicted_key),
    .estimate_o   (estimate),
    .error_bound_o(error_bound),
    .total_seen_o (total_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watch both handshakes and the quiet-cycle watchdog
  always @(posedge clk) begin
    hh_report_t seen_word;
    bit         moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        board.count_key(item_key);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        seen_word = '{was_tracked, did_evict, evicted_key, estimate, error_bound, total_seen};
        board.match_word(seen_word);
        moved = 1'b1;
      end
      if (moved || (board.pending.size() == 0 && !in_valid)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // receiver: random stall stretches, plus one long hold on request
  initial begin
    int unsigned hold_left, stretch, mode;
    hold_left = 0;
    stretch = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 2);
          stretch = $urandom_range(5, 60);
        end
        stretch--;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 1) == 1);
          end
          default: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CAP_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_capacity(input logic [31:0] value);
    logic [31:0] rdata;
    apb_access(1'b1, value, rdata);
    board.set_capacity(value);
    apb_access(1'b0, '0, rdata);
    if (rdata !== {21'b0, value[CAP_BITS-1:0]}) begin
      $display("%0t: capacity readback expected %h actual %h", $time,
               {21'b0, value[CAP_BITS-1:0]}, rdata);
      cfg_errors++;
    end
  endtask

  // offer one word; pace the sender in bursts with random gaps
  task automatic send_key(input logic [31:0] key);
    int unsigned gap;
    in_valid <= 1'b1;
    item_key <= key;
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  task automatic run_phase(input logic [31:0] cap_value, input int unsigned n_items,
                           input int unsigned pool_size, input bit hold,
                           input int unsigned pause_at);
    logic [31:0] key, last_key;
    int unsigned roll;
    wait_drained();
    write_capacity(cap_value);
    hot_keys.delete();
    repeat (pool_size) hot_keys.push_back($urandom);
    last_key = hot_keys[0];
    hold_request = hold;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      // skewed pick from the hot pool so heavy hitters form
      if (roll < 70) begin
        key = hot_keys[$urandom_range(0, $urandom_range(0, pool_size - 1))];
      end else if (roll < 85) begin
        key = $urandom;
      end else begin
        key = last_key;
      end
      send_key(key);
      last_key = key;
      if (n == pause_at) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero capacity acts as one slot: after the first fill every new key evicts
    write_capacity(32'd0);
    send_key(32'h0000_0000);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    wait_drained();

    // upper data bits are dropped: three slots, then ties on the least count
    write_capacity(32'hFFFF_F803);
    send_key(32'h0000_0001);
    send_key(32'h0000_0002);
    send_key(32'h0000_0003);
    send_key(32'h5555_5555);
    send_key(32'hAAAA_AAAA);
    send_key(32'h0000_0003);
    send_key(32'h5555_5555);
    wait_drained();

    // capacity below the slots in use: no new slot, all still searched
    write_capacity(32'd1);
    send_key(32'h8000_0001);
    send_key(32'h0000_FFFF);
    send_key(32'h0000_0002);
    send_key(32'h8000_0001);

    run_phase(32'd8, 150, 12, 1'b1, 200);
    run_phase(32'd16, 150, 24, 1'b0, 75);
    run_phase(32'd2, 80, 12, 1'b0, 40);
    run_phase(32'd2047, 100, 20, 1'b0, 200);
    run_phase(32'd1024, 100, 20, 1'b0, 50);

    wait_drained();
    repeat (120) @(posedge clk);

    $display("Counted %0d keys: %0d hits on held slots, %0d free-slot fills, %0d evictions",
             board.n_hits + board.n_fills + board.n_evicts, board.n_hits, board.n_fills,
             board.n_evicts);
    $display("Capacity swept 0, 1, 2, 3, 8, 16, 1024 and 2047; %0d slots in use at the end",
             board.slots_taken);
    if (board.mismatches == 0 && cfg_errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[space_saving_counter_table_unit.f]
rtl/core/sscnt_pkg.sv
rtl/core/sscnt_slot_ram.sv
rtl/core/sscnt_scan_unit.sv
rtl/core/space_saving_counter_table_unit.sv
tb/testbench.sv
